### src/ddcf_pkg.sv
`default_nettype none

package ddcf_pkg;

  localparam int unsigned FrameLen = 16;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  localparam logic [7:0] HdrB0    = 8'hAA;
  localparam logic [7:0] HdrB1    = 8'h7F;
  localparam logic [7:0] HdrB2    = 8'h01;
  localparam logic [7:0] HdrB3    = 8'h00;
  localparam logic [7:0] HdrB4    = 8'h01;
  localparam logic [7:0] ModeMove = 8'h01;
  localparam logic [7:0] ModeStop = 8'h03;
  localparam logic [7:0] EndByte  = 8'h55;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [9:0] RadiusRst = 10'd100;

  // |x| div 1000 as (|x| * ceil(2^37/1000)) >> 37, exact for |x| < 2^26
  localparam int unsigned MagW      = 26;
  localparam int unsigned RecipShft = 37;
  localparam logic [27:0] Recip1000 = 28'd137438954;
  localparam int unsigned QuotW     = 17;

  // Register word addresses
  localparam logic [0:0] RegRadius = 1'b0;

  typedef struct packed {
    logic        moving;
    logic        dir_b7;
    logic        dir_b8;
    logic [15:0] left;
    logic [15:0] right;
  } ddcf_cmd_t;

endpackage

`default_nettype wire

### src/ddcf_front.sv
`default_nettype none

module ddcf_front import ddcf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [9:0]  radius_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] speed_i,
  input  wire logic [15:0] yaw_i,
  output logic             cmd_valid_o,
  input  wire logic        cmd_ready_i,
  output ddcf_cmd_t        cmd_o
);

  logic adv;

  logic                    s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [2:0]              s1_fl_q, s2_fl_q, s3_fl_q, s4_fl_q;
  logic signed [25:0]      base_q;
  logic signed [26:0]      turn_q;
  logic signed [26:0]      sum_l_q, sum_r_q;
  logic [MagW-1:0]         mag_l_q, mag_r_q;
  logic [QuotW-1:0]        quo_l_q, quo_r_q;

  logic signed [15:0] spd, yaw;
  logic signed [25:0] spd_x;
  logic signed [26:0] turn_d;
  logic [2:0]         fl_d;
  logic [53:0]        prod_l, prod_r;

  assign spd = $signed(speed_i);
  assign yaw = $signed(yaw_i);
  assign spd_x = 26'(spd);
  assign turn_d = 27'(yaw) * $signed({17'd0, radius_i});

  // flags: {moving, byte 7 bit, byte 8 bit}
  always_comb begin
    if (yaw > 16'sd0) begin
      fl_d = 3'b111;
    end else if (yaw < 16'sd0) begin
      fl_d = 3'b100;
    end else if (spd > 16'sd0) begin
      fl_d = 3'b101;
    end else if (spd < 16'sd0) begin
      fl_d = 3'b110;
    end else begin
      fl_d = 3'b000;
    end
  end

  assign prod_l = 54'(mag_l_q) * 54'(Recip1000);
  assign prod_r = 54'(mag_r_q) * 54'(Recip1000);

  // Hold the whole pipe while the last stage cannot hand off
  assign adv        = !(s4_v_q && !cmd_ready_i);
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // speed * 1000 as shifts and subtracts
      base_q  <= (spd_x <<< 10) - (spd_x <<< 4) - (spd_x <<< 3);
      turn_q  <= turn_d;
      s1_fl_q <= fl_d;
      sum_l_q <= 27'(base_q) - turn_q;
      sum_r_q <= 27'(base_q) + turn_q;
      s2_fl_q <= s1_fl_q;
      mag_l_q <= sum_l_q[26] ? MagW'(-sum_l_q) : MagW'(sum_l_q);
      mag_r_q <= sum_r_q[26] ? MagW'(-sum_r_q) : MagW'(sum_r_q);
      s3_fl_q <= s2_fl_q;
      quo_l_q <= prod_l[RecipShft +: QuotW];
      quo_r_q <= prod_r[RecipShft +: QuotW];
      s4_fl_q <= s3_fl_q;
    end
  end

  assign cmd_valid_o  = s4_v_q;
  assign cmd_o.moving = s4_fl_q[2];
  assign cmd_o.dir_b7 = s4_fl_q[1];
  assign cmd_o.dir_b8 = s4_fl_q[0];
  assign cmd_o.left   = quo_l_q[QuotW-1] ? 16'hFFFF : quo_l_q[15:0];
  assign cmd_o.right  = quo_r_q[QuotW-1] ? 16'hFFFF : quo_r_q[15:0];

endmodule

`default_nettype wire

### src/ddcf_queue.sv
`default_nettype none

module ddcf_queue import ddcf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_valid_i,
  output logic            push_ready_o,
  input  wire ddcf_cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  wire logic       pop_i,
  output ddcf_cmd_t       pop_data_o
);

  ddcf_cmd_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && pop_valid_o && !push_valid_i) |=> push_ready_o)
    else $error("queue still full after pop");

endmodule

`default_nettype wire

### src/ddcf_back.sv
`default_nettype none

module ddcf_back import ddcf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  input  wire ddcf_cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_data_o,
  output logic            out_last_o
);

  logic [IdxW-1:0] idx_q;
  logic [15:0]     crc_q;
  logic            valid_q;
  logic [7:0]      data_q;
  logic            last_q;

  logic            load;
  logic [7:0]      byte_d;
  logic [15:0]     crc_base;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  always_comb begin
    case (idx_q)
      4'd0:    byte_d = HdrB0;
      4'd1:    byte_d = HdrB1;
      4'd2:    byte_d = HdrB2;
      4'd3:    byte_d = HdrB3;
      4'd4:    byte_d = HdrB4;
      4'd5,
      4'd6:    byte_d = cmd_i.moving ? ModeMove : ModeStop;
      4'd7:    byte_d = {7'd0, cmd_i.dir_b7};
      4'd8:    byte_d = {7'd0, cmd_i.dir_b8};
      4'd9:    byte_d = cmd_i.left[15:8];
      4'd10:   byte_d = cmd_i.left[7:0];
      4'd11:   byte_d = cmd_i.right[15:8];
      4'd12:   byte_d = cmd_i.right[7:0];
      4'd13:   byte_d = EndByte;
      4'd14:   byte_d = crc_q[7:0];
      default: byte_d = crc_q[15:8];
    endcase
  end

  assign crc_base  = (idx_q == '0) ? CrcInit : crc_q;
  assign load      = cmd_valid_i && (!valid_q || out_ready_i);
  assign cmd_pop_o = load && (idx_q == IdxW'(FrameLen - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_q + 1'b1;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= byte_d;
      last_q <= (idx_q == IdxW'(FrameLen - 1));
      // Fold header, payload and end bytes into the checksum
      if (idx_q < IdxW'(FrameLen - 2)) begin
        crc_q <= crc_byte(crc_base, byte_d);
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

### src/diff_drive_command_framer.sv
// Channel   Dir  Payload
// s_axis    in   tdata[15:0] speed_mm_s, tdata[31:16] yaw_mrad_s
// m_axis    out  tdata[7:0] frame_byte, tlast last_byte
// apb       in   word 0: wheel_radius_mm[9:0]
//
// One command in gives a 16-byte frame out, one byte per cycle while m_axis is
// ready; the byte sequencer takes one command per frame and so sets the rate.
// Wheel speeds come out of a 4-stage pipe (multiply, add, magnitude,
// reciprocal multiply) and wait in a 2-entry queue for the sequencer.
// The checksum is built as bytes go out, one byte per cycle while m_axis is ready.
// rst_ni clears all control state; the radius register resets to 100.
// A stall on m_axis fills the queue and then backs up into s_axis.
`default_nettype none

module diff_drive_command_framer import ddcf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] speed_mm_s, [31:16] yaw_mrad_s
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] frame_byte
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [9:0] radius_q;
  logic       cfg_wr;

  logic       f_valid, f_ready, q_valid, q_pop;
  ddcf_cmd_t  f_cmd, q_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegRadius) ? {22'd0, radius_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusRst;
    end else if (cfg_wr && paddr[2] == RegRadius) begin
      radius_q <= pwdata[9:0];
    end
  end

  ddcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_i    (radius_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .speed_i     (s_axis_tdata[15:0]),
    .yaw_i       (s_axis_tdata[31:16]),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  ddcf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_cmd)
  );

  ddcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

### bench/diff_drive_command_framer_test.sv
module diff_drive_command_framer_test;
  import ddcf_pkg::*;

  localparam logic [2:0] RadiusAddr   = 3'd0;
  localparam logic [2:0] SpareAddr    = 3'd4;
  localparam int         RandPerPhase = 98;
  localparam int         QuietLimit   = 1000;
  localparam int         MaxReports   = 40;

  typedef enum logic [1:0] {RowTyped, RowPredicted, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] spd;
    logic [15:0] yaw;
    ddcf_cmd_t   cmd;
    logic [2:0]  addr;
    logic [31:0] wdata;
  } plan_row_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    int         frame;
    int         pos;
  } frame_byte_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [15:0] speed_mm_s, [31:16] yaw_mrad_s
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] frame_byte
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_byte_t frame_bytes[$];
  logic [9:0]  radius_q     = RadiusRst;
  int          frames_sent  = 0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  int          stall_cycles = 0;
  bit          idling_on    = 1'b1;
  plan_row_t   plan [25];

  diff_drive_command_framer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("ERROR %s: got %0h, want %0h", what, got, want);
    end
  endtask

  function automatic logic [15:0] sat_speed(input longint x);
    longint q;
    q = ((x < 0) ? -x : x) / 1000;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic ddcf_cmd_t wheel_cmd(input logic [15:0] spd, input logic [15:0] yaw,
                                          input logic [9:0] rad);
    ddcf_cmd_t c;
    longint    fwd;
    longint    turn;
    fwd  = longint'($signed(spd)) * 1000;
    turn = longint'($signed(yaw)) * longint'(rad);
    c.left   = sat_speed(fwd - turn);
    c.right  = sat_speed(fwd + turn);
    c.moving = 1'b1;
    if ($signed(yaw) > 0) begin
      c.dir_b7 = 1'b1; c.dir_b8 = 1'b1;
    end else if ($signed(yaw) < 0) begin
      c.dir_b7 = 1'b0; c.dir_b8 = 1'b0;
    end else if ($signed(spd) > 0) begin
      c.dir_b7 = 1'b0; c.dir_b8 = 1'b1;
    end else if ($signed(spd) < 0) begin
      c.dir_b7 = 1'b1; c.dir_b8 = 1'b0;
    end else begin
      c.moving = 1'b0; c.dir_b7 = 1'b0; c.dir_b8 = 1'b0;
    end
    return c;
  endfunction

  // Lay out the frame, seal it with the checksum and queue its bytes
  function automatic void queue_frame(input ddcf_cmd_t c);
    logic [7:0]  f [FrameLen];
    logic [15:0] crc;
    frame_byte_t fb;
    f[0]  = HdrB0;
    f[1]  = HdrB1;
    f[2]  = HdrB2;
    f[3]  = HdrB3;
    f[4]  = HdrB4;
    f[5]  = c.moving ? ModeMove : ModeStop;
    f[6]  = f[5];
    f[7]  = {7'd0, c.dir_b7};
    f[8]  = {7'd0, c.dir_b8};
    f[9]  = c.left[15:8];
    f[10] = c.left[7:0];
    f[11] = c.right[15:8];
    f[12] = c.right[7:0];
    f[13] = EndByte;
    crc = CrcInit;
    for (int i = 0; i < FrameLen - 2; i++) begin
      crc ^= {8'd0, f[i]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
      end
    end
    f[14] = crc[7:0];
    f[15] = crc[15:8];
    for (int i = 0; i < FrameLen; i++) begin
      fb.data  = f[i];
      fb.last  = (i == FrameLen - 1);
      fb.frame = frames_sent;
      fb.pos   = i;
      frame_bytes.push_back(fb);
    end
    frames_sent++;
  endfunction

  function automatic logic [15:0] pick_rate();
    logic [15:0] mag;
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      2, 3: begin
        mag = 16'($urandom_range(1, 3000));
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
      end
      default: return 16'($urandom());
    endcase
  endfunction

  // Every task below starts just after a rising edge; send_cmd and write_cfg end on one, wait_drained on either edge
  task automatic send_cmd(input logic [15:0] spd, input logic [15:0] yaw, input ddcf_cmd_t want);
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {yaw, spd};
    do @(posedge clk_i); while (!s_axis_tready);
    queue_frame(want);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (frame_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Write a register, then read the radius back
  task automatic write_cfg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((addr >> 2) == RegRadius) radius_q = data[9:0];
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RadiusAddr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {22'd0, radius_q}) flag_mismatch("radius readback", prdata, radius_q);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver stalls in bursts, started only while idling_on is set
  always @(negedge clk_i) begin
    if (stall_cycles > 0) begin
      stall_cycles--;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      stall_cycles = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_bytes.size() == 0) begin
          flag_mismatch("byte with no frame pending", m_axis_tdata, 0);
        end else begin
          want = frame_bytes.pop_front();
          if (m_axis_tdata !== want.data) begin
            flag_mismatch($sformatf("frame %0d byte %0d frame_byte", want.frame, want.pos),
                          m_axis_tdata, want.data);
          end
          if (m_axis_tlast !== want.last) begin
            flag_mismatch($sformatf("frame %0d byte %0d last_byte", want.frame, want.pos),
                          m_axis_tlast, want.last);
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] spd;
    logic [15:0] yaw;
    logic [31:0] wdata;

    // Radius 100 out of reset, then 1023, 0, an ignored write and back to 100
    plan = '{
      '{RowTyped,     16'h0000, 16'h0000, '{1'b0, 1'b0, 1'b0, 16'd0,     16'd0},     3'd0, 32'd0},
      '{RowTyped,     16'h0001, 16'h0000, '{1'b1, 1'b0, 1'b1, 16'd1,     16'd1},     3'd0, 32'd0},
      '{RowTyped,     16'hFFFF, 16'h0000, '{1'b1, 1'b1, 1'b0, 16'd1,     16'd1},     3'd0, 32'd0},
      '{RowTyped,     16'h7FFF, 16'h0000, '{1'b1, 1'b0, 1'b1, 16'd32767, 16'd32767}, 3'd0, 32'd0},
      '{RowTyped,     16'h8000, 16'h0000, '{1'b1, 1'b1, 1'b0, 16'd32768, 16'd32768}, 3'd0, 32'd0},
      '{RowTyped,     16'h0000, 16'h0001, '{1'b1, 1'b1, 1'b1, 16'd0,     16'd0},     3'd0, 32'd0},
      '{RowTyped,     16'h0000, 16'hFFFF, '{1'b1, 1'b0, 1'b0, 16'd0,     16'd0},     3'd0, 32'd0},
      '{RowTyped,     16'h0000, 16'h7FFF, '{1'b1, 1'b1, 1'b1, 16'd3276,  16'd3276},  3'd0, 32'd0},
      '{RowTyped,     16'h0000, 16'h8000, '{1'b1, 1'b0, 1'b0, 16'd3276,  16'd3276},  3'd0, 32'd0},
      '{RowTyped,     16'h7FFF, 16'h7FFF, '{1'b1, 1'b1, 1'b1, 16'd29490, 16'd36043}, 3'd0, 32'd0},
      '{RowTyped,     16'h8000, 16'h8000, '{1'b1, 1'b0, 1'b0, 16'd29491, 16'd36044}, 3'd0, 32'd0},
      '{RowTyped,     16'h7FFF, 16'h8000, '{1'b1, 1'b0, 1'b0, 16'd36043, 16'd29490}, 3'd0, 32'd0},
      '{RowTyped,     16'h8000, 16'h7FFF, '{1'b1, 1'b1, 1'b1, 16'd36044, 16'd29491}, 3'd0, 32'd0},
      '{RowPredicted, 16'h04D2, 16'hFDC9, '0,                                          3'd0, 32'd0},
      '{RowPredicted, 16'hFFFF, 16'h0001, '0,                                          3'd0, 32'd0},
      '{RowWrite,     16'h0000, 16'h0000, '0,                                RadiusAddr, 32'hFFFFFFFF},
      '{RowTyped,     16'h7FFF, 16'h7FFF, '{1'b1, 1'b1, 1'b1, 16'd753,   16'd65535}, 3'd0, 32'd0},
      '{RowTyped,     16'h8000, 16'h7FFF, '{1'b1, 1'b1, 1'b1, 16'd65535, 16'd752},   3'd0, 32'd0},
      '{RowTyped,     16'h0000, 16'h8000, '{1'b1, 1'b0, 1'b0, 16'd33521, 16'd33521}, 3'd0, 32'd0},
      '{RowWrite,     16'h0000, 16'h0000, '0,                                RadiusAddr, 32'hFFFFFC00},
      '{RowTyped,     16'h0005, 16'h7FFF, '{1'b1, 1'b1, 1'b1, 16'd5,     16'd5},     3'd0, 32'd0},
      '{RowWrite,     16'h0000, 16'h0000, '0,                                SpareAddr,  32'h000003FF},
      '{RowTyped,     16'hFFF9, 16'hFFFF, '{1'b1, 1'b0, 1'b0, 16'd7,     16'd7},     3'd0, 32'd0},
      '{RowWrite,     16'h0000, 16'h0000, '0,                                RadiusAddr, 32'd100},
      '{RowPredicted, 16'h0320, 16'h0BB8, '0,                                          3'd0, 32'd0}
    };

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        RowWrite: begin
          wait_drained();
          write_cfg(plan[i].addr, plan[i].wdata);
        end
        RowTyped: send_cmd(plan[i].spd, plan[i].yaw, plan[i].cmd);
        default:  send_cmd(plan[i].spd, plan[i].yaw, wheel_cmd(plan[i].spd, plan[i].yaw, radius_q));
      endcase
    end

    // Random radius, full radius, zero radius, random radius with no stalls
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        1:       wdata = $urandom() | 32'h3FF;
        2:       wdata = $urandom() & ~32'h3FF;
        default: wdata = $urandom();
      endcase
      write_cfg(RadiusAddr, wdata);
      idling_on = (phase != 3);
      for (int n = 0; n < RandPerPhase; n++) begin
        if ($urandom_range(0, 49) == 0) wait_drained();
        spd = pick_rate();
        yaw = pick_rate();
        if ($urandom_range(0, 19) == 0) begin
          spd = '0;
          yaw = '0;
        end
        send_cmd(spd, yaw, wheel_cmd(spd, yaw, radius_q));
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
